// ----- sv/vertex_normal_accumulator_defines.svh -----
// Assertion macros used by the checker file.
`ifndef VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VNA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vertex normal accumulator: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VNA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vertex normal accumulator: assertion failed");

`endif

// ----- sv/vna_pkg.sv -----
package vna_pkg;

	localparam int VERTEX_SLOTS = 4096;
	localparam int COORD_BITS = 16;
	localparam int SUM_BITS = 48;

	localparam int IDX_W = 12;
	localparam int FIELD_W = 16;
	localparam int ADDR_W = $clog2(VERTEX_SLOTS);
	localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int VTX_W = 3 * CW;
	localparam int EDGE_W = CW + 1;
	localparam int NRM_W = 2 * EDGE_W + 1;
	localparam int SUMS_W = 3 * SUM_BITS;
	localparam int MAG_W = 30;
	localparam int MUL_W = (EDGE_W > MAG_W + 1) ? EDGE_W : MAG_W + 1;
	localparam int PROD_W = 2 * MUL_W;
	localparam int SQ_W = 2 * MAG_W + 2;
	localparam int LEN_W = MAG_W + 1;
	localparam int REM_W = LEN_W + 1;
	localparam int Q_W = 16;
	localparam int DVD_W = MAG_W + Q_W;
	localparam int CNT_W = 16;

	localparam int IN_DATA_W = 96;
	localparam int IN_USER_W = 2;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_FACE  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		VA_IDX = 2'd0,
		VA_A   = 2'd1,
		VA_B   = 2'd2,
		VA_C   = 2'd3
	} vsel_t;

	typedef enum logic [3:0] {
		MS_UYWZ = 4'd0,
		MS_UZWY = 4'd1,
		MS_UZWX = 4'd2,
		MS_UXWZ = 4'd3,
		MS_UXWY = 4'd4,
		MS_UYWX = 4'd5,
		MS_SQX  = 4'd6,
		MS_SQY  = 4'd7,
		MS_SQZ  = 4'd8
	} msel_t;

	typedef struct packed {
		logic              in_load;
		logic              vram_we;
		logic              vram_re;
		vsel_t             vram_sel;
		logic              cap_a;
		logic              cap_b;
		logic              cap_c;
		logic              cap_edge;
		logic              mul_en;
		msel_t             mul_sel;
		logic              sum_re;
		logic              sum_we;
		logic              sum_clr;
		vsel_t             sum_sel;
		logic [ADDR_W-1:0] sweep_addr;
		logic              cnt_inc;
		logic              cnt_clr;
		logic              load_mag;
		logic              norm_step;
		logic              sqrt_init;
		logic              sqrt_step;
		logic              div_init;
		logic              div_step;
		logic              div_store;
		logic [1:0]        comp;
		logic              out_load;
		logic              out_zero;
	} cmd_t;

	typedef struct packed {
		logic idx_ok;
		logic face_ok;
		logic n_zero;
		logic sum_zero;
		logic norm_hi;
		logic norm_lo;
		logic sqrt_done;
	} stat_t;

	function automatic logic slot_ok(logic [IDX_W-1:0] i);
		return 32'(i) < 32'(VERTEX_SLOTS);
	endfunction

	function automatic logic [ADDR_W-1:0] to_addr(logic [IDX_W-1:0] i);
		return ADDR_W'(i);
	endfunction

endpackage

// ----- sv/vna_ram.sv -----
module vna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/vna_ctrl.sv -----
module vna_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  vna_pkg::op_t   in_op,
	output logic           out_valid,
	input  logic           out_ready,
	output vna_pkg::cmd_t  cmd,
	input  vna_pkg::stat_t stat
);

	import vna_pkg::*;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_WV,
		S_FA, S_FB, S_FC, S_FD, S_FE, S_FM, S_FW, S_FZ, S_FR, S_FU,
		S_RA, S_RL, S_RZ, S_RN, S_RS, S_RW, S_RQ, S_DI, S_DS, S_DT, S_RO
	} state_t;

	localparam logic [3:0] MUL_LAST = 4'd5;
	localparam logic [3:0] DIV_LAST = 4'(Q_W - 1);
	localparam logic [1:0] COMP_LAST = 2'd2;
	localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(VERTEX_SLOTS - 1);

	state_t state_q;
	logic [3:0] step_q;
	logic [1:0] comp_q;
	logic [ADDR_W-1:0] sweep_q;
	logic zero_q;
	logic out_valid_q;
	logic accept;

	function automatic vsel_t corner_sel(logic [1:0] c);
		vsel_t s;
		unique case (c)
			2'd0: s = VA_A;
			2'd1: s = VA_B;
			default: s = VA_C;
		endcase
		return s;
	endfunction

	function automatic msel_t square_sel(logic [1:0] c);
		msel_t s;
		unique case (c)
			2'd0: s = MS_SQX;
			2'd1: s = MS_SQY;
			default: s = MS_SQZ;
		endcase
		return s;
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.in_load = accept;
		cmd.sweep_addr = sweep_q;
		cmd.comp = comp_q;
		unique case (state_q)
			S_CLR: begin
				cmd.sum_clr = 1'b1;
				cmd.cnt_clr = 1'b1;
			end
			S_WV: cmd.vram_we = stat.idx_ok;
			S_FA: begin
				cmd.vram_re = 1'b1;
				cmd.vram_sel = VA_A;
			end
			S_FB: begin
				cmd.vram_re = 1'b1;
				cmd.vram_sel = VA_B;
				cmd.cap_a = 1'b1;
			end
			S_FC: begin
				cmd.vram_re = 1'b1;
				cmd.vram_sel = VA_C;
				cmd.cap_b = 1'b1;
			end
			S_FD: cmd.cap_c = 1'b1;
			S_FE: cmd.cap_edge = 1'b1;
			S_FM: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = msel_t'(step_q);
			end
			S_FZ: cmd.cnt_inc = stat.n_zero;
			S_FR: begin
				cmd.sum_re = 1'b1;
				cmd.sum_sel = corner_sel(comp_q);
			end
			S_FU: begin
				cmd.sum_we = 1'b1;
				cmd.sum_sel = corner_sel(comp_q);
			end
			S_RA: begin
				cmd.sum_re = 1'b1;
				cmd.sum_sel = VA_IDX;
			end
			S_RL: cmd.load_mag = 1'b1;
			S_RN: cmd.norm_step = 1'b1;
			S_RS: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = square_sel(comp_q);
			end
			S_RW: cmd.sqrt_init = 1'b1;
			S_RQ: cmd.sqrt_step = !stat.sqrt_done;
			S_DI: cmd.div_init = 1'b1;
			S_DS: cmd.div_step = 1'b1;
			S_DT: cmd.div_store = 1'b1;
			S_RO: begin
				cmd.out_load = !out_valid_q || out_ready;
				cmd.out_zero = zero_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			step_q <= '0;
			comp_q <= '0;
			sweep_q <= '0;
			zero_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (sweep_q == SWEEP_LAST) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (in_op)
							OP_WRITE: state_q <= S_WV;
							OP_FACE: state_q <= S_FA;
							OP_READ: state_q <= S_RA;
							OP_CLEAR: state_q <= S_CLR;
						endcase
					end
				end
				S_WV: state_q <= S_IDLE;
				S_FA: state_q <= stat.face_ok ? S_FB : S_IDLE;
				S_FB: state_q <= S_FC;
				S_FC: state_q <= S_FD;
				S_FD: state_q <= S_FE;
				S_FE: begin
					step_q <= '0;
					state_q <= S_FM;
				end
				S_FM: begin
					if (step_q == MUL_LAST) begin
						step_q <= '0;
						state_q <= S_FW;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_FW: state_q <= S_FZ;
				S_FZ: begin
					comp_q <= '0;
					state_q <= stat.n_zero ? S_IDLE : S_FR;
				end
				S_FR: state_q <= S_FU;
				S_FU: begin
					if (comp_q == COMP_LAST) begin
						comp_q <= '0;
						state_q <= S_IDLE;
					end else begin
						comp_q <= comp_q + 1'b1;
						state_q <= S_FR;
					end
				end
				S_RA: state_q <= S_RL;
				S_RL: state_q <= S_RZ;
				S_RZ: begin
					zero_q <= stat.sum_zero;
					state_q <= stat.sum_zero ? S_RO : S_RN;
				end
				S_RN: begin
					if (!stat.norm_hi && !stat.norm_lo) begin
						comp_q <= '0;
						state_q <= S_RS;
					end
				end
				S_RS: begin
					if (comp_q == COMP_LAST) begin
						comp_q <= '0;
						state_q <= S_RW;
					end else begin
						comp_q <= comp_q + 1'b1;
					end
				end
				S_RW: state_q <= S_RQ;
				S_RQ: begin
					if (stat.sqrt_done) begin
						state_q <= S_DI;
					end
				end
				S_DI: begin
					step_q <= '0;
					state_q <= S_DS;
				end
				S_DS: begin
					if (step_q == DIV_LAST) begin
						step_q <= '0;
						state_q <= S_DT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DT: begin
					if (comp_q == COMP_LAST) begin
						comp_q <= '0;
						state_q <= S_RO;
					end else begin
						comp_q <= comp_q + 1'b1;
						state_q <= S_DI;
					end
				end
				S_RO: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/vna_dp.sv -----
module vna_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vna_pkg::cmd_t                    cmd,
	output vna_pkg::stat_t                   stat,
	input  logic [vna_pkg::IN_DATA_W-1:0]    in_data,
	output logic [vna_pkg::OUT_DATA_W-1:0]   out_data,
	output logic                             out_zero
);

	import vna_pkg::*;

	localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W - 1){1'b1}}};
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	logic [IDX_W-1:0] idx_q, ca_q, cb_q, cc_q;
	logic [CW-1:0] cx_q, cy_q, cz_q;
	logic [VTX_W-1:0] va_q, vb_q, vc_q, vram_rdata;
	logic signed [EDGE_W-1:0] ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
	logic signed [MUL_W-1:0] opa, opb;
	logic signed [PROD_W-1:0] prod_s1;
	logic mul_en_s1;
	msel_t mul_sel_s1;
	logic signed [NRM_W-1:0] nx_q, ny_q, nz_q;
	logic [SQ_W-1:0] sq_q, root_q, bit_q, trial;
	logic [ADDR_W-1:0] vaddr, saddr;
	logic [SUMS_W-1:0] sum_rdata, sum_wdata;
	logic signed [SUM_BITS-1:0] sx, sy, sz;
	logic [SUM_BITS-1:0] amx, amy, amz, amax;
	logic [SUM_BITS-1:0] mx_q, my_q, mz_q, mm_q;
	logic [2:0] sgn_q;
	logic [LEN_W-1:0] len;
	logic [MAG_W-1:0] dmag;
	logic dsgn;
	logic [DVD_W-1:0] dvd;
	logic [REM_W-1:0] rem_q, dtrial;
	logic [Q_W-1:0] dq_q, qv;
	logic dge;
	logic [Q_W-1:0] rx_q, ry_q, rz_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [ADDR_W-1:0] pick(vsel_t s, logic [IDX_W-1:0] i,
			logic [IDX_W-1:0] a, logic [IDX_W-1:0] b, logic [IDX_W-1:0] c);
		logic [IDX_W-1:0] r;
		unique case (s)
			VA_IDX: r = i;
			VA_A: r = a;
			VA_B: r = b;
			VA_C: r = c;
		endcase
		return to_addr(r);
	endfunction

	function automatic logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] a,
			logic signed [NRM_W-1:0] b);
		logic signed [SUM_BITS:0] s;
		s = signed'({a[SUM_BITS-1], a}) + (SUM_BITS + 1)'(b);
		if (s[SUM_BITS] != s[SUM_BITS-1]) begin
			return s[SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}} : {1'b0, {(SUM_BITS - 1){1'b1}}};
		end
		return s[SUM_BITS-1:0];
	endfunction

	function automatic logic signed [EDGE_W-1:0] edge_of(logic [VTX_W-1:0] p,
			logic [VTX_W-1:0] q, int k);
		return EDGE_W'(signed'(p[k*CW +: CW])) - EDGE_W'(signed'(q[k*CW +: CW]));
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			idx_q <= in_data[IDX_W-1:0];
			cx_q <= in_data[IDX_W +: CW];
			cy_q <= in_data[IDX_W + FIELD_W +: CW];
			cz_q <= in_data[IDX_W + 2 * FIELD_W +: CW];
			ca_q <= in_data[IDX_W + 3 * FIELD_W +: IDX_W];
			cb_q <= in_data[2 * IDX_W + 3 * FIELD_W +: IDX_W];
			cc_q <= in_data[3 * IDX_W + 3 * FIELD_W +: IDX_W];
		end
	end

	assign stat.idx_ok = slot_ok(idx_q);
	assign stat.face_ok = slot_ok(ca_q) && slot_ok(cb_q) && slot_ok(cc_q);
	assign stat.n_zero = (nx_q == '0) && (ny_q == '0) && (nz_q == '0);
	assign stat.sum_zero = (mm_q == '0);
	assign stat.norm_hi = |mm_q[SUM_BITS-1:MAG_W];
	assign stat.norm_lo = !mm_q[MAG_W-1] && !stat.norm_hi;
	assign stat.sqrt_done = (bit_q == '0);

	assign vaddr = pick(cmd.vram_sel, idx_q, ca_q, cb_q, cc_q);

	vna_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_SLOTS)) u_vertex_ram (
		.clk   (clk),
		.we    (cmd.vram_we),
		.waddr (to_addr(idx_q)),
		.wdata ({cz_q, cy_q, cx_q}),
		.re    (cmd.vram_re),
		.raddr (vaddr),
		.rdata (vram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			va_q <= vram_rdata;
		end
		if (cmd.cap_b) begin
			vb_q <= vram_rdata;
		end
		if (cmd.cap_c) begin
			vc_q <= vram_rdata;
		end
		if (cmd.cap_edge) begin
			ux_q <= edge_of(vb_q, va_q, 0);
			uy_q <= edge_of(vb_q, va_q, 1);
			uz_q <= edge_of(vb_q, va_q, 2);
			wx_q <= edge_of(vc_q, va_q, 0);
			wy_q <= edge_of(vc_q, va_q, 1);
			wz_q <= edge_of(vc_q, va_q, 2);
		end
	end

	always_comb begin
		case (cmd.mul_sel)
			MS_UYWZ: begin opa = MUL_W'(uy_q); opb = MUL_W'(wz_q); end
			MS_UZWY: begin opa = MUL_W'(uz_q); opb = MUL_W'(wy_q); end
			MS_UZWX: begin opa = MUL_W'(uz_q); opb = MUL_W'(wx_q); end
			MS_UXWZ: begin opa = MUL_W'(ux_q); opb = MUL_W'(wz_q); end
			MS_UXWY: begin opa = MUL_W'(ux_q); opb = MUL_W'(wy_q); end
			MS_UYWX: begin opa = MUL_W'(uy_q); opb = MUL_W'(wx_q); end
			MS_SQX: begin opa = MUL_W'(mx_q[MAG_W-1:0]); opb = opa; end
			MS_SQY: begin opa = MUL_W'(my_q[MAG_W-1:0]); opb = opa; end
			MS_SQZ: begin opa = MUL_W'(mz_q[MAG_W-1:0]); opb = opa; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_en_s1 <= 1'b0;
		end else begin
			mul_en_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
		mul_sel_s1 <= cmd.mul_sel;
	end

	assign trial = root_q + bit_q;

	always_ff @(posedge clk) begin
		if (mul_en_s1) begin
			case (mul_sel_s1)
				MS_UYWZ: nx_q <= prod_s1[NRM_W-1:0];
				MS_UZWY: nx_q <= nx_q - prod_s1[NRM_W-1:0];
				MS_UZWX: ny_q <= prod_s1[NRM_W-1:0];
				MS_UXWZ: ny_q <= ny_q - prod_s1[NRM_W-1:0];
				MS_UXWY: nz_q <= prod_s1[NRM_W-1:0];
				MS_UYWX: nz_q <= nz_q - prod_s1[NRM_W-1:0];
				MS_SQX: sq_q <= prod_s1[SQ_W-1:0];
				MS_SQY: sq_q <= sq_q + prod_s1[SQ_W-1:0];
				MS_SQZ: sq_q <= sq_q + prod_s1[SQ_W-1:0];
				default: ;
			endcase
		end
		if (cmd.sqrt_init) begin
			root_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (cmd.sqrt_step) begin
			if (sq_q >= trial) begin
				sq_q <= sq_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign saddr = pick(cmd.sum_sel, idx_q, ca_q, cb_q, cc_q);
	assign sum_wdata = cmd.sum_clr ? '0 : {
		sat_add(sum_rdata[2 * SUM_BITS +: SUM_BITS], nz_q),
		sat_add(sum_rdata[SUM_BITS +: SUM_BITS], ny_q),
		sat_add(sum_rdata[0 +: SUM_BITS], nx_q)};

	vna_ram #(.WIDTH(SUMS_W), .DEPTH(VERTEX_SLOTS)) u_sum_ram (
		.clk   (clk),
		.we    (cmd.sum_we || cmd.sum_clr),
		.waddr (cmd.sum_clr ? cmd.sweep_addr : saddr),
		.wdata (sum_wdata),
		.re    (cmd.sum_re),
		.raddr (saddr),
		.rdata (sum_rdata)
	);

	always_comb begin
		sx = stat.idx_ok ? signed'(sum_rdata[0 +: SUM_BITS]) : '0;
		sy = stat.idx_ok ? signed'(sum_rdata[SUM_BITS +: SUM_BITS]) : '0;
		sz = stat.idx_ok ? signed'(sum_rdata[2 * SUM_BITS +: SUM_BITS]) : '0;
		amx = sx[SUM_BITS-1] ? -sx : sx;
		amy = sy[SUM_BITS-1] ? -sy : sy;
		amz = sz[SUM_BITS-1] ? -sz : sz;
		amax = (amx > amy) ? amx : amy;
		amax = (amz > amax) ? amz : amax;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_mag) begin
			mx_q <= amx;
			my_q <= amy;
			mz_q <= amz;
			mm_q <= amax;
			sgn_q <= {sz[SUM_BITS-1], sy[SUM_BITS-1], sx[SUM_BITS-1]};
		end else if (cmd.norm_step) begin
			if (stat.norm_hi) begin
				mx_q <= mx_q >> 1;
				my_q <= my_q >> 1;
				mz_q <= mz_q >> 1;
				mm_q <= mm_q >> 1;
			end else if (stat.norm_lo) begin
				mx_q <= mx_q << 1;
				my_q <= my_q << 1;
				mz_q <= mz_q << 1;
				mm_q <= mm_q << 1;
			end
		end
	end

	assign len = root_q[LEN_W-1:0];

	always_comb begin
		unique case (cmd.comp)
			2'd0: begin dmag = mx_q[MAG_W-1:0]; dsgn = sgn_q[0]; end
			2'd1: begin dmag = my_q[MAG_W-1:0]; dsgn = sgn_q[1]; end
			2'd2: begin dmag = mz_q[MAG_W-1:0]; dsgn = sgn_q[2]; end
			default: begin dmag = '0; dsgn = 1'b0; end
		endcase
		dvd = DVD_W'({dmag, {(Q_W - 1){1'b0}}}) + DVD_W'(len >> 1);
		dtrial = {rem_q[REM_W-2:0], dq_q[Q_W-1]};
		dge = dtrial >= REM_W'(len);
		if (dsgn) begin
			qv = -dq_q;
		end else begin
			qv = (dq_q > POS_MAX) ? POS_MAX : dq_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= REM_W'(dvd[DVD_W-1:Q_W]);
			dq_q <= dvd[Q_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= dge ? dtrial - REM_W'(len) : dtrial;
			dq_q <= {dq_q[Q_W-2:0], dge};
		end
		if (cmd.div_store) begin
			unique case (cmd.comp)
				2'd0: rx_q <= qv;
				2'd1: ry_q <= qv;
				default: rz_q <= qv;
			endcase
		end
		if (cmd.out_load) begin
			out_data <= cmd.out_zero ? {cnt_q, {(3 * Q_W){1'b0}}} : {cnt_q, rz_q, ry_q, rx_q};
			out_zero <= cmd.out_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc && cnt_q != CNT_MAX) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

// ----- sv/vertex_normal_accumulator.sv -----
// Area-weighted vertex normal accumulator. Requests carry an operation in
// s_axis_tuser: write a vertex, add a triangle face, read a normal, or clear
// all normal sums and the zero-area face count. A face is worked through
// three vertex memory reads, six products through one shared multiplier and
// three read-modify-writes of the sum memory; a face of zero area skips the
// writes. A normal read takes up to 29 one-bit normalising shifts, 31
// square-root steps and three 16-bit restoring divisions, one bit a cycle;
// a zero-length sum skips them. A clear, and likewise the start after reset,
// zeroes the 4096-entry sum memory one entry a cycle, so the block takes no
// request until the sweep is done. Only a read gives a result, held in an
// output register so the next request may be taken while it waits.
module vertex_normal_accumulator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
	input  logic [vna_pkg::IN_DATA_W-1:0]          s_axis_tdata,
	// operation
	input  logic [vna_pkg::IN_USER_W-1:0]          s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// unit_x, unit_y, unit_z, degenerate_faces
	output logic [vna_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	// zero_normal
	output logic [vna_pkg::OUT_USER_W-1:0]         m_axis_tuser
);

	import vna_pkg::*;

	cmd_t cmd;
	stat_t stat;

	vna_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (op_t'(s_axis_tuser)),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	vna_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (s_axis_tdata),
		.out_data (m_axis_tdata),
		.out_zero (m_axis_tuser[0])
	);

endmodule

// ----- sv/vna_checker.sv -----
`include "vertex_normal_accumulator_defines.svh"

module vna_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_axis_tvalid,
	input logic                                   s_axis_tready,
	input logic [vna_pkg::IN_DATA_W-1:0]          s_axis_tdata,
	input logic [vna_pkg::IN_USER_W-1:0]          s_axis_tuser,
	input logic                                   m_axis_tvalid,
	input logic                                   m_axis_tready,
	input logic [vna_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	input logic [vna_pkg::OUT_USER_W-1:0]         m_axis_tuser
);

	import vna_pkg::*;

	// One request is worked on at a time.
	`VNA_ASSERT_NEXT(a_one_request, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// A zero-length normal carries zero components.
	`VNA_ASSERT_NOW(a_zero_normal, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[3*Q_W-1:0] == '0)

	`VNA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);
